// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the chi-square block.
// All checks use clk_i and are disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define CSQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When pre holds at one edge, post must hold at the next.
`define CSQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/csq_pkg.sv -----
package csq_pkg;

  // Tally and length width.
  localparam int CSQ_CNT_W     = 24;
  // Expected-count registers.
  localparam int CSQ_NUM_EXP   = 4;
  localparam int CSQ_EXP_W     = 32;
  localparam int CSQ_CFG_IDX_W = $clog2(CSQ_NUM_EXP);
  // Statistic format.
  localparam int CSQ_CHI_W     = 48;
  localparam int CSQ_FRAC_W    = 16;

  // Derived datapath widths.
  localparam int CSQ_SUM_W  = CSQ_EXP_W + $clog2(CSQ_NUM_EXP);  // S
  localparam int CSQ_OS_W   = CSQ_CNT_W + CSQ_SUM_W;            // o*S
  localparam int CSQ_LE_W   = CSQ_CNT_W + CSQ_EXP_W;            // L*E
  localparam int CSQ_MPL_W  = CSQ_OS_W;                         // widest multiplier
  localparam int CSQ_DEN_W  = CSQ_SUM_W + CSQ_LE_W;             // S*L*E
  localparam int CSQ_WIDE_W = CSQ_DEN_W + CSQ_CHI_W;            // den << 48
  localparam int CSQ_DIV_CNT_W = $clog2(CSQ_CHI_W);

  localparam logic [CSQ_CHI_W-1:0] CSQ_CHI_MAX = '1;

  // Stream payload widths.
  localparam int CSQ_IN_DATA_W  = 8;
  localparam int CSQ_IN_USER_W  = 2;
  localparam int CSQ_OUT_BITS   = 5 * CSQ_CNT_W + CSQ_CHI_W;
  localparam int CSQ_OUT_DATA_W = ((CSQ_OUT_BITS + 7) / 8) * 8;

  // Input tuser bit positions.
  localparam int CSQ_USER_REV   = 0;
  localparam int CSQ_USER_EMPTY = 1;

  // Base slots; complement pairs are A/T and C/G.
  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  // Lower-case sequence characters.
  localparam logic [7:0] CHAR_A = 8'h61;
  localparam logic [7:0] CHAR_C = 8'h63;
  localparam logic [7:0] CHAR_G = 8'h67;
  localparam logic [7:0] CHAR_T = 8'h74;

  typedef logic [CSQ_CNT_W-1:0] csq_cnt_t;
  typedef logic [CSQ_EXP_W-1:0] csq_exp_t;

  typedef enum logic {
    CSQ_OP_ADD,
    CSQ_OP_SUB
  } csq_op_e;

  typedef struct packed {
    logic busy;
    logic done;
  } csq_eng_stat_t;

endpackage

// ----- rtl/csq_addsub.sv -----
module csq_addsub
  import csq_pkg::*;
(
  input  csq_op_e                 op_i,
  input  logic [CSQ_WIDE_W-1:0]   a_i,
  input  logic [CSQ_WIDE_W-1:0]   b_i,
  output logic [CSQ_WIDE_W-1:0]   res_o,
  // Carry out on add, borrow (a < b) on subtract.
  output logic                    cout_o
);

  logic [CSQ_WIDE_W:0] full;

  always_comb begin
    case (op_i)
      CSQ_OP_SUB: full = {1'b0, a_i} - {1'b0, b_i};
      CSQ_OP_ADD: full = {1'b0, a_i} + {1'b0, b_i};
      default:    full = {1'b0, a_i} + {1'b0, b_i};
    endcase
  end

  assign res_o  = full[CSQ_WIDE_W-1:0];
  assign cout_o = full[CSQ_WIDE_W];

endmodule

// ----- rtl/csq_tally.sv -----
`include "assert_macros.svh"

module csq_tally
  import csq_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       beat_i,
  input  logic [CSQ_IN_DATA_W-1:0]   nucleotide_i,
  input  logic                       reverse_strand_i,
  input  logic                       empty_region_i,
  input  logic                       clear_i,
  output csq_cnt_t [3:0]             tally_o,
  output csq_cnt_t                   len_o
);

  csq_cnt_t [3:0] tally_q, tally_d;
  csq_cnt_t       len_q, len_d;
  logic [1:0]     slot;
  logic           is_base;

  function automatic csq_cnt_t sat_inc(input csq_cnt_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  always_comb begin
    is_base = 1'b1;
    case (nucleotide_i)
      CHAR_A:  slot = reverse_strand_i ? BASE_T : BASE_A;
      CHAR_C:  slot = reverse_strand_i ? BASE_G : BASE_C;
      CHAR_G:  slot = reverse_strand_i ? BASE_C : BASE_G;
      CHAR_T:  slot = reverse_strand_i ? BASE_A : BASE_T;
      default: begin
        slot    = BASE_A;
        is_base = 1'b0;
      end
    endcase
  end

  always_comb begin
    tally_d = tally_q;
    len_d   = len_q;
    if (clear_i || (beat_i && empty_region_i)) begin
      tally_d = '0;
      len_d   = '0;
    end else if (beat_i) begin
      len_d = sat_inc(len_q);
      if (is_base) begin
        tally_d[slot] = sat_inc(tally_q[slot]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q <= '0;
      len_q   <= '0;
    end else begin
      tally_q <= tally_d;
      len_q   <= len_d;
    end
  end

  assign tally_o = tally_q;
  assign len_o   = len_q;

  // Every tallied byte also counted toward the length.
  `CSQ_ASSERT(a_tally_within_len, (tally_q[BASE_A] <= len_q) && (tally_q[BASE_C] <= len_q) && (tally_q[BASE_G] <= len_q) && (tally_q[BASE_T] <= len_q), "tally exceeds region length")

endmodule

// ----- rtl/csq_engine.sv -----
`include "assert_macros.svh"

module csq_engine
  import csq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   empty_i,
  input  logic                   ack_i,
  input  csq_exp_t [3:0]         exp_i,
  input  csq_cnt_t [3:0]         tally_i,
  input  csq_cnt_t               len_i,
  output csq_eng_stat_t          stat_o,
  output logic [CSQ_CHI_W-1:0]   chi_o,
  output logic                   chi_valid_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL_OS,
    ST_MUL_LE,
    ST_MUL_DEN,
    ST_ABS,
    ST_MUL_SQ,
    ST_SAT,
    ST_DIV,
    ST_ACCUM,
    ST_DONE
  } state_e;

  state_e                     st_q;
  logic [1:0]                 idx_q;
  logic [CSQ_WIDE_W-1:0]      acc_q;
  logic [CSQ_WIDE_W-1:0]      mcand_q;
  logic [CSQ_MPL_W-1:0]       mplier_q;
  logic [CSQ_OS_W-1:0]        os_q;
  logic [CSQ_LE_W-1:0]        le_q;
  logic [CSQ_DEN_W-1:0]       den_q;
  logic [CSQ_CHI_W-1:0]       quo_q;
  logic [CSQ_CHI_W-1:0]       chi_q;
  logic [CSQ_DIV_CNT_W-1:0]   cnt_q;
  logic [CSQ_SUM_W-1:0]       s_q;
  logic                       ok_q;

  csq_op_e                    au_op;
  logic [CSQ_WIDE_W-1:0]      au_res;
  logic                       au_cout;
  logic [CSQ_SUM_W-1:0]       exp_sum;
  logic                       exp_nz;
  logic [CSQ_CHI_W:0]         chi_sum;

  always_comb begin
    exp_sum = '0;
    exp_nz  = 1'b1;
    for (int i = 0; i < CSQ_NUM_EXP; i++) begin
      exp_sum = exp_sum + CSQ_SUM_W'(exp_i[i]);
      exp_nz  = exp_nz && (exp_i[i] != '0);
    end
  end

  assign au_op = (st_q == ST_ABS || st_q == ST_SAT || st_q == ST_DIV) ? CSQ_OP_SUB
                                                                      : CSQ_OP_ADD;

  csq_addsub u_addsub (
    .op_i   (au_op),
    .a_i    (acc_q),
    .b_i    (mcand_q),
    .res_o  (au_res),
    .cout_o (au_cout)
  );

  assign chi_sum = {1'b0, chi_q} + {1'b0, quo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      idx_q    <= BASE_A;
      acc_q    <= '0;
      mcand_q  <= '0;
      mplier_q <= '0;
      os_q     <= '0;
      le_q     <= '0;
      den_q    <= '0;
      quo_q    <= '0;
      chi_q    <= '0;
      cnt_q    <= '0;
      s_q      <= '0;
      ok_q     <= 1'b0;
    end else begin
      case (st_q)
        ST_IDLE: begin
          if (start_i) begin
            s_q   <= exp_sum;
            ok_q  <= !empty_i && exp_nz;
            chi_q <= '0;
            idx_q <= BASE_A;
            st_q  <= (!empty_i && exp_nz) ? ST_LOAD : ST_DONE;
          end
        end
        ST_LOAD: begin
          acc_q    <= '0;
          mcand_q  <= CSQ_WIDE_W'(s_q);
          mplier_q <= CSQ_MPL_W'(tally_i[idx_q]);
          st_q     <= ST_MUL_OS;
        end
        ST_MUL_OS, ST_MUL_LE, ST_MUL_DEN, ST_MUL_SQ: begin
          if (mplier_q == '0) begin
            case (st_q)
              ST_MUL_OS: begin
                os_q     <= acc_q[CSQ_OS_W-1:0];
                acc_q    <= '0;
                mcand_q  <= CSQ_WIDE_W'(exp_i[idx_q]);
                mplier_q <= CSQ_MPL_W'(len_i);
                st_q     <= ST_MUL_LE;
              end
              ST_MUL_LE: begin
                le_q     <= acc_q[CSQ_LE_W-1:0];
                acc_q    <= '0;
                mcand_q  <= CSQ_WIDE_W'(acc_q[CSQ_LE_W-1:0]);
                mplier_q <= CSQ_MPL_W'(s_q);
                st_q     <= ST_MUL_DEN;
              end
              ST_MUL_DEN: begin
                den_q   <= acc_q[CSQ_DEN_W-1:0];
                acc_q   <= CSQ_WIDE_W'(os_q);
                mcand_q <= CSQ_WIDE_W'(le_q);
                st_q    <= ST_ABS;
              end
              default: begin
                // Squared difference scaled by the fraction bits.
                acc_q   <= acc_q << CSQ_FRAC_W;
                mcand_q <= {den_q, {CSQ_CHI_W{1'b0}}};
                st_q    <= ST_SAT;
              end
            endcase
          end else begin
            if (mplier_q[0]) begin
              acc_q <= au_res;
            end
            mcand_q  <= mcand_q << 1;
            mplier_q <= mplier_q >> 1;
          end
        end
        ST_ABS: begin
          if (au_cout) begin
            // Negative difference: swap operands and subtract again.
            acc_q   <= mcand_q;
            mcand_q <= acc_q;
          end else begin
            acc_q    <= '0;
            mcand_q  <= au_res;
            mplier_q <= au_res[CSQ_MPL_W-1:0];
            st_q     <= ST_MUL_SQ;
          end
        end
        ST_SAT: begin
          if (!au_cout) begin
            quo_q <= CSQ_CHI_MAX;
            st_q  <= ST_ACCUM;
          end else begin
            mcand_q <= mcand_q >> 1;
            quo_q   <= '0;
            cnt_q   <= CSQ_DIV_CNT_W'(CSQ_CHI_W - 1);
            st_q    <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (!au_cout) begin
            acc_q <= au_res;
          end
          quo_q   <= {quo_q[CSQ_CHI_W-2:0], !au_cout};
          mcand_q <= mcand_q >> 1;
          if (cnt_q == '0) begin
            st_q <= ST_ACCUM;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_ACCUM: begin
          chi_q <= chi_sum[CSQ_CHI_W] ? CSQ_CHI_MAX : chi_sum[CSQ_CHI_W-1:0];
          if (idx_q == BASE_T) begin
            st_q <= ST_DONE;
          end else begin
            idx_q <= idx_q + 1'b1;
            st_q  <= ST_LOAD;
          end
        end
        ST_DONE: begin
          if (ack_i) begin
            st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign stat_o.busy  = (st_q != ST_IDLE);
  assign stat_o.done  = (st_q == ST_DONE);
  assign chi_o        = chi_q;
  assign chi_valid_o  = ok_q;

  // Restoring division keeps the remainder below twice the current divisor.
  `CSQ_ASSERT(a_div_rem_bound, (st_q != ST_DIV) || ({1'b0, acc_q} < {mcand_q, 1'b0}), "division remainder out of range")
  // A new region may only start the sequencer when it is idle.
  `CSQ_ASSERT(a_start_when_idle, !start_i || (st_q == ST_IDLE), "start while sequencer busy")
  // The result is released to the output stage only from the done state.
  `CSQ_ASSERT(a_ack_in_done, !ack_i || (st_q == ST_DONE), "acknowledge outside done state")

endmodule

// ----- rtl/base_composition_chi_square_core.sv -----
// Channel     Direction  Beat contents
// s_axis      in         tdata: nucleotide; tuser: reverse_strand, empty_region;
//                        tlast: last_base
// m_axis      out        tdata: count_a..t, region_length, chi_square;
//                        tuser: chi_valid
// cfg         in         write-only expected_a..t, index 0..3
//
// Bytes that do not end a region are taken one per cycle while the sequencer is idle.
// A region end starts the chi-square sequencer: four terms, each built from
// shift-add multiplies and a 48-step restoring division on one shared adder.
// Empty regions and zero expected counts go straight to done with chi_valid low.
// Input tready stays low while the sequencer runs or its result waits for the
// output register; reset clears tallies, configuration and the output valid.
`include "assert_macros.svh"

module base_composition_chi_square_core
  import csq_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic [CSQ_CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [CSQ_EXP_W-1:0]         cfg_wdata_i,
  // Input stream.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [CSQ_IN_DATA_W-1:0]     s_axis_tdata,   // [7:0] nucleotide
  input  logic [CSQ_IN_USER_W-1:0]     s_axis_tuser,   // [0] reverse_strand, [1] empty_region
  input  logic                         s_axis_tlast,   // last_base
  // Output stream.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // Low bit up: count_a, count_c, count_g, count_t, region_length, chi_square.
  output logic [CSQ_OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                         m_axis_tuser    // [0] chi_valid
);

  csq_exp_t [3:0]              exp_q;
  csq_cnt_t [3:0]              tally;
  csq_cnt_t                    tally_len;
  csq_eng_stat_t               eng_stat;
  logic [CSQ_CHI_W-1:0]        eng_chi;
  logic                        eng_chi_valid;
  logic                        in_beat;
  logic                        region_end;
  logic                        out_load;
  logic                        out_valid_q;
  logic [CSQ_OUT_DATA_W-1:0]   out_data_q;
  logic                        out_user_q;
  logic                        out_fresh;

  // Expected counts; the user must write them only while the block is idle (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= '0;
    end else if (cfg_we_i) begin
      exp_q[cfg_addr_i] <= cfg_wdata_i;
    end
  end

  assign s_axis_tready = !eng_stat.busy;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign region_end    = in_beat && (s_axis_tlast || s_axis_tuser[CSQ_USER_EMPTY]);

  csq_tally u_tally (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .beat_i           (in_beat),
    .nucleotide_i     (s_axis_tdata),
    .reverse_strand_i (s_axis_tuser[CSQ_USER_REV]),
    .empty_region_i   (s_axis_tuser[CSQ_USER_EMPTY]),
    .clear_i          (out_load),
    .tally_o          (tally),
    .len_o            (tally_len)
  );

  csq_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (region_end),
    .empty_i     (s_axis_tuser[CSQ_USER_EMPTY]),
    .ack_i       (out_load),
    .exp_i       (exp_q),
    .tally_i     (tally),
    .len_i       (tally_len),
    .stat_o      (eng_stat),
    .chi_o       (eng_chi),
    .chi_valid_o (eng_chi_valid)
  );

  // The finished result moves into the output register once it is free, and
  // the tallies are cleared on the same edge for the next region.
  assign out_load = eng_stat.done && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_user_q  <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
      out_data_q  <= CSQ_OUT_DATA_W'({eng_chi, tally_len, tally[BASE_T], tally[BASE_G],
                                      tally[BASE_C], tally[BASE_A]});
      out_user_q  <= eng_chi_valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  assign out_fresh = (tally_len == '0) && m_axis_tvalid;

  // A region starts from zero after its result has been handed on.
  `CSQ_ASSERT_NEXT(a_clear_after_load, out_load, out_fresh, "region not cleared after load")

endmodule
